### rtl/tte_pkg.sv
// Shared types and constants for the tap tempo estimator.
package tte_pkg;

  localparam int unsigned TAP_W         = 32;
  localparam int unsigned TIMEOUT_W     = 16;
  localparam int unsigned BPM_W         = 18;
  localparam int unsigned DIVISOR_W     = 31;
  localparam int unsigned BPM_PER_SPAN  = 60000;
  localparam int unsigned BPM_MAX       = 262143;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_PUSH
  } tte_state_t;

  typedef struct packed {
    logic accept;
    logic calc;
    logic div_step;
    logic push;
  } tte_cmd_t;

  typedef struct packed {
    logic div_done;
  } tte_sts_t;

endpackage

### rtl/tte_ctrl.sv
// Sequencing state machine and result handshake for the tap tempo estimator.
module tte_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  tte_pkg::tte_sts_t sts,
  output tte_pkg::tte_cmd_t cmd
);

  tte_pkg::tte_state_t state_r;
  tte_pkg::tte_state_t state_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                can_push;

  assign can_push = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tte_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tte_pkg::ST_CALC;
      end
      tte_pkg::ST_CALC: state_nxt = tte_pkg::ST_DIV;
      tte_pkg::ST_DIV: begin
        if (sts.div_done) state_nxt = tte_pkg::ST_PUSH;
      end
      tte_pkg::ST_PUSH: begin
        if (can_push) state_nxt = tte_pkg::ST_IDLE;
      end
      default: state_nxt = tte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      tte_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      tte_pkg::ST_CALC: cmd.calc     = 1'b1;
      tte_pkg::ST_DIV:  cmd.div_step = 1'b1;
      tte_pkg::ST_PUSH: cmd.push     = can_push;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tte_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/tte_dp.sv
// Tap history, interval span, bit-serial divider and result register.
module tte_dp #(
  parameter int unsigned QUEUE_LEN = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [tte_pkg::TIMEOUT_W-1:0]   cfg_wr_data,
  input  logic [tte_pkg::TAP_W-1:0]       in_tap_time_ms,
  output logic [tte_pkg::BPM_W-1:0]       out_tempo_bpm,
  input  tte_pkg::tte_cmd_t               cmd,
  output tte_pkg::tte_sts_t               sts
);

  localparam int unsigned DIVIDEND = tte_pkg::BPM_PER_SPAN * (QUEUE_LEN - 1);
  localparam int unsigned DW       = $clog2(DIVIDEND + 1);
  localparam int unsigned CW       = $clog2(DW);
  localparam int unsigned DVW      = tte_pkg::DIVISOR_W;

  logic [tte_pkg::TAP_W-1:0]     hist_r [QUEUE_LEN];
  logic [tte_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [tte_pkg::TAP_W-1:0]     gap;
  logic                          restart;
  logic [tte_pkg::TAP_W-1:0]     span;
  logic                          full;
  logic                          zero_nxt;
  logic                          zero_r;
  logic [DVW-1:0]                divisor_r;
  logic [DVW-1:0]                rem_r;
  logic [DVW-1:0]                rem_nxt;
  logic [DW-1:0]                 quo_r;
  logic [DVW:0]                  trial;
  logic                          ge;
  logic [CW-1:0]                 cnt_r;
  logic [31:0]                   quo_ext;
  logic [tte_pkg::BPM_W-1:0]     bpm_nxt;
  logic [tte_pkg::BPM_W-1:0]     tempo_r;

  assign gap     = in_tap_time_ms - hist_r[QUEUE_LEN-1];
  assign restart = gap > {{(tte_pkg::TAP_W - tte_pkg::TIMEOUT_W){1'b0}}, timeout_r};

  // The wrapped intervals telescope, so their sum is newest minus oldest.
  assign span = hist_r[QUEUE_LEN-1] - hist_r[0];

  always_comb begin
    full = 1'b1;
    for (int i = 0; i < QUEUE_LEN - 1; i++) begin
      if (hist_r[i] == '0) full = 1'b0;
    end
  end

  assign zero_nxt = !full || (span == '0) || span[tte_pkg::TAP_W-1];

  assign trial   = {rem_r, quo_r[DW-1]};
  assign ge      = trial >= {1'b0, divisor_r};
  assign rem_nxt = ge ? DVW'(trial - {1'b0, divisor_r}) : trial[DVW-1:0];

  assign quo_ext = 32'(quo_r);
  always_comb begin
    if (zero_r) begin
      bpm_nxt = '0;
    end else if (quo_ext > 32'(tte_pkg::BPM_MAX)) begin
      bpm_nxt = tte_pkg::BPM_W'(tte_pkg::BPM_MAX);
    end else begin
      bpm_nxt = quo_ext[tte_pkg::BPM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= tte_pkg::TIMEOUT_RESET;
      for (int i = 0; i < QUEUE_LEN; i++) hist_r[i] <= '0;
    end else begin
      if (cfg_wr_en) timeout_r <= cfg_wr_data;
      if (cmd.accept) begin
        for (int i = 0; i < QUEUE_LEN - 1; i++) begin
          hist_r[i] <= restart ? '0 : hist_r[i+1];
        end
        hist_r[QUEUE_LEN-1] <= in_tap_time_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      zero_r    <= zero_nxt;
      divisor_r <= span[DVW-1:0];
      rem_r     <= '0;
      quo_r     <= DW'(DIVIDEND);
      cnt_r     <= CW'(DW - 1);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DW-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.push) tempo_r <= bpm_nxt;
  end

  assign sts.div_done  = (cnt_r == '0);
  assign out_tempo_bpm = tempo_r;

endmodule

### rtl/tap_tempo_estimator.sv
// Top level of the tap tempo estimator.
// Each accepted tap updates a short history of timestamps and yields one tempo item.
// After an accepted tap the span is registered in the calc state, the restoring divider
// works through the DW = ceil(log2(60000*(QUEUE_LEN-1)+1)) dividend bits, and the result
// register is loaded in the push state; only then is the input free again.
// The divider gives one quotient bit per cycle; no tap is taken while one is in work.
// A new tap is taken while a finished tempo still waits on out_stall; the next result
// is held back only if the previous one has not been taken when the divider finishes,
// and while it is held back the next tap is not taken.
module tap_tempo_estimator #(
  parameter int unsigned QUEUE_LEN = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [tte_pkg::TIMEOUT_W-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tte_pkg::TAP_W-1:0]     in_tap_time_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tte_pkg::BPM_W-1:0]     out_tempo_bpm
);

  tte_pkg::tte_cmd_t cmd;
  tte_pkg::tte_sts_t sts;

  tte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tte_dp #(
    .QUEUE_LEN (QUEUE_LEN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tap_time_ms (in_tap_time_ms),
    .out_tempo_bpm  (out_tempo_bpm),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

### rtl/tte_checker.sv
// Port-level assertions for the tap tempo estimator and their bind.
module tte_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [tte_pkg::BPM_W-1:0] out_tempo_bpm
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Input not stalled while an item is in work.");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result appeared without an item in work.");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tempo_bpm))
    else $error("Stalled result changed or was dropped.");

endmodule

bind tap_tempo_estimator tte_checker u_tte_checker (.*);

### test/tte_tempo_checker.sv
// Checker that predicts each tempo item from the taps and compares it with the block output.
`timescale 1ns / 1ps

module tte_tempo_checker
  import tte_pkg::*;
#(
  parameter int unsigned QUEUE_LEN = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [TIMEOUT_W-1:0] cfg_wr_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [TAP_W-1:0]     in_tap_time_ms,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [BPM_W-1:0]     out_tempo_bpm,
  output int                   fail_count,
  output int                   pending,
  output int                   taps_seen,
  output int                   tempos_nonzero
);

  logic [TAP_W-1:0]     history [QUEUE_LEN];
  logic [TIMEOUT_W-1:0] timeout;
  logic [BPM_W-1:0]     awaited_tempos [$];
  int                   n_fail = 0;
  int                   n_taps = 0;
  int                   n_nonzero = 0;

  function automatic logic [BPM_W-1:0] tempo_after_tap(input logic [TAP_W-1:0] tap);
    logic [TAP_W-1:0] gap;
    logic [TAP_W-1:0] span;
    logic [63:0]      quot;
    logic             all_set;
    gap = tap - history[QUEUE_LEN-1];
    for (int i = 0; i < QUEUE_LEN - 1; i++) begin
      history[i] = (gap > TAP_W'(timeout)) ? '0 : history[i+1];
    end
    history[QUEUE_LEN-1] = tap;
    all_set = 1'b1;
    span = '0;
    for (int i = 0; i < QUEUE_LEN - 1; i++) begin
      if (history[i] == '0) all_set = 1'b0;
      span += history[i+1] - history[i];
    end
    if (!all_set || span == '0 || span[TAP_W-1]) return '0;
    quot = (64'(BPM_PER_SPAN) * 64'(QUEUE_LEN - 1)) / 64'(span);
    if (quot > 64'(BPM_MAX)) quot = 64'(BPM_MAX);
    return quot[BPM_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [BPM_W-1:0] want;
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_LEN; i++) history[i] = '0;
      timeout = TIMEOUT_RESET;
      awaited_tempos.delete();
    end else begin
      if (cfg_wr_en) timeout = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (awaited_tempos.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("%0t: tempo item %0d arrived with none expected", $time, out_tempo_bpm);
          end
        end else begin
          want = awaited_tempos.pop_front();
          if (want != 0) n_nonzero++;
          if (want != out_tempo_bpm) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: tempo_bpm expected %0d, got %0d", $time, want, out_tempo_bpm);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        awaited_tempos.push_back(tempo_after_tap(in_tap_time_ms));
        n_taps++;
      end
    end
    pending        <= awaited_tempos.size();
    fail_count     <= n_fail;
    taps_seen      <= n_taps;
    tempos_nonzero <= n_nonzero;
  end

endmodule

### test/tb_tap_tempo_estimator.sv
// Top of the tap tempo estimator testbench: clock, reset, tap and timeout stimulus, verdict.
`timescale 1ns / 1ps

module tb_tap_tempo_estimator;
  import tte_pkg::*;

  localparam int unsigned QUEUE_LEN      = 4;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          PHASE_TAPS     = 200;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [TIMEOUT_W-1:0] cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [TAP_W-1:0]     in_tap_time_ms;
  logic                 out_valid;
  logic                 out_stall;
  logic [BPM_W-1:0]     out_tempo_bpm;

  int fail_count;
  int pending;
  int taps_seen;
  int tempos_nonzero;

  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  int               hold_req_cnt = 0;
  int               taps_sent = 0;
  int               timeout_writes = 0;
  int unsigned      window = TIMEOUT_RESET;
  logic [TAP_W-1:0] last_tap = '0;

  tap_tempo_estimator #(.QUEUE_LEN(QUEUE_LEN)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_tap_time_ms (in_tap_time_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tempo_bpm  (out_tempo_bpm)
  );

  tte_tempo_checker #(.QUEUE_LEN(QUEUE_LEN)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_tap_time_ms (in_tap_time_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tempo_bpm  (out_tempo_bpm),
    .fail_count     (fail_count),
    .pending        (pending),
    .taps_seen      (taps_seen),
    .tempos_nonzero (tempos_nonzero)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : tempo_receiver
    int served;
    served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (served != hold_req_cnt) begin
        served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tap_tempo_estimator regression: fail");
    $finish;
  end

  task automatic send_tap(input logic [TAP_W-1:0] tap);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_tap_time_ms <= tap;
    do @(posedge clk); while (in_stall);
    last_tap = tap;
    taps_sent++;
  endtask

  task automatic wait_all_tempos();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_timeout(input int unsigned value);
    wait_all_tempos();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[TIMEOUT_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window = value;
    timeout_writes++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return window + 1 + $urandom_range(5000);
    if (r < 6) return $urandom_range((window < 8) ? window : 8);
    return $urandom_range(window);
  endfunction

  task automatic tap_burst(input int len);
    if ($urandom_range(2) == 0) send_tap($urandom);
    else send_tap(last_tap + window + 1 + $urandom_range(100000));
    for (int i = 1; i < len; i++) send_tap(last_tap + pick_gap());
  endtask

  task automatic odd_tap();
    case ($urandom_range(2))
      0: send_tap($urandom);
      1: send_tap('0);
      default: send_tap(last_tap);
    endcase
  endtask

  logic [TAP_W-1:0] directed_taps [25] = '{
    32'd0, 32'hFFFF_FFFF, 32'd499, 32'd999, 32'd1499,
    32'hFFFF_FA24, 32'hFFFF_FC18, 32'hFFFF_FE0C, 32'd0,
    32'd100000, 32'd103000, 32'd106000, 32'd109000, 32'd112001,
    32'd5, 32'd5, 32'd5, 32'd5, 32'd6, 32'd7, 32'd8,
    32'd20, 32'd20, 32'd20, 32'd21
  };
  int unsigned timeout_plan [9] = '{65535, 1, 0, 3000, 0, 40, 0, 65535, 500};

  initial begin : stimulus
    int phase_end;
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    in_tap_time_ms <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_taps[i]) send_tap(directed_taps[i]);

    for (int p = 0; p < 9; p++) begin
      if (p == 4 || p == 6) write_timeout($urandom_range(65535));
      else write_timeout(timeout_plan[p]);
      tx_idle_pct = (p < 3) ? 37 : (p < 6) ? 70 : 0;
      rx_idle_pct = (p < 3) ? 70 : (p < 6) ? 37 : 0;
      phase_end = taps_sent + PHASE_TAPS;
      if (p == 6) begin
        hold_req_cnt++;
        tap_burst(12);
      end
      while (taps_sent < phase_end) begin
        if ($urandom_range(9) < 8) tap_burst($urandom_range(4, 9));
        else odd_tap();
      end
    end

    wait_all_tempos();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d taps, %0d of them giving a nonzero tempo,", taps_seen,
             tempos_nonzero);
    $display("over %0d timeout settings and a long output hold.", timeout_writes + 1);
    if (fail_count == 0) begin
      $display("tap_tempo_estimator regression: pass");
    end else begin
      $display("tap_tempo_estimator regression: fail");
    end
    $finish;
  end

endmodule
